/* hdl/i2cra_pkg.sv */
// Shared types and constants for the I2C register access master.
`timescale 1ns / 1ps
package i2cra_pkg;

  localparam int unsigned MaxBurst = 256;
  localparam int unsigned LeftW    = $clog2(MaxBurst + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_PHASE     = 2'd1;
  localparam logic [1:0] CFG_ACK_LIMIT = 2'd2;

  // Command opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ1 = 2'd1;
  localparam logic [1:0] OP_BURST = 2'd2;
  localparam logic [1:0] OP_WAKE  = 2'd3;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // Byte stages within a transaction
  localparam logic [2:0] STG_DEV   = 3'd0;
  localparam logic [2:0] STG_REG   = 3'd1;
  localparam logic [2:0] STG_DATA  = 3'd2;
  localparam logic [2:0] STG_RSTRT = 3'd3;
  localparam logic [2:0] STG_RDEV  = 3'd4;

  localparam logic [7:0] ReadBit = 8'h01;
  localparam logic [7:0] AckLimitRst = 8'd250;
  localparam logic [7:0] PhaseRst    = 8'd4;

endpackage

/* hdl/i2cra_if.sv */
// Channel interfaces: command/tick input, result output, configuration write.
`timescale 1ns / 1ps
interface i2cra_in_if;
  import i2cra_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [1:0]       op;
  logic [7:0]       reg_addr;
  logic [7:0]       wr_data;
  logic [LeftW-1:0] burst_len;
  logic             sda_in;

  modport source (output valid, kind, op, reg_addr, wr_data, burst_len, sda_in,
                  input ready);
  modport sink   (input valid, kind, op, reg_addr, wr_data, burst_len, sda_in,
                  output ready);
endinterface

interface i2cra_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_drive_low;
  logic       busy_res;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       done_res;
  logic       status;

  modport source (output valid, scl, sda_drive_low, busy_res, data_valid, data_byte,
                  last_byte, done_res, status, input ready);
  modport sink   (input valid, scl, sda_drive_low, busy_res, data_valid, data_byte,
                  last_byte, done_res, status, output ready);
endinterface

interface i2cra_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* hdl/i2c_master_register_access.sv */
// I2C master sequencer running register write, read, burst read and wake-up transactions.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  in_i    | in  | valid/ready   | kind, op, reg_addr, wr_data, burst_len, sda_in
//  res_o   | out | valid/ready   | scl, sda_drive_low, busy_res, data_valid,
//          |     |               | data_byte, last_byte, done_res, status
//  cfg_i   | in  | valid/ready   | addr (register index), data
//
// One item per cycle while res_o is not stalled: the sequencer state steps at the
// accepting edge and the result lands in a one-deep output register in the same cycle.
// in_i.ready stays high while the output register is empty or being drained,
// so a stalled res_o holds at most one result. cfg_i is always ready.
// Reset (rst_ni low, asynchronous) returns the bus to idle and loads the
// register defaults.
`timescale 1ns / 1ps
module i2c_master_register_access
  import i2cra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cra_in_if.sink    in_i,
  i2cra_out_if.source res_o,
  i2cra_cfg_if.sink   cfg_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_SEND  = 3'd2;
  localparam logic [2:0] ST_ACK   = 3'd3;
  localparam logic [2:0] ST_RECV  = 3'd4;
  localparam logic [2:0] ST_MACK  = 3'd5;
  localparam logic [2:0] ST_STOP  = 3'd6;

  // configuration
  logic [7:0] dev_addr_q, phase_ticks_q, ack_limit_q;

  // sequencer state
  logic [2:0]       seq_q, seq_d;
  logic [7:0]       phase_q, phase_d;
  logic [2:0]       bit_q, bit_d;
  logic [7:0]       shift_q, shift_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [7:0]       wait_q, wait_d;
  logic [1:0]       op_q, op_d;
  logic [7:0]       reg_q, reg_d;
  logic [7:0]       data_q, data_d;
  logic [2:0]       stage_q, stage_d;
  logic [1:0]       half_q, half_d;
  logic             err_q, err_d;

  // result register
  logic       rvalid_q;
  logic       scl_q, low_q, busy_q, dv_q, lb_q, done_q, stat_q;
  logic [7:0] db_q;

  logic       scl_c, low_c, dv_c, lb_c, done_c, stat_c;
  logic [7:0] db_c;
  logic [7:0] pt;
  logic [8:0] phase_inc;
  logic [LeftW-1:0] left_dec;
  logic       in_acc;

  assign in_i.ready  = !rvalid_q || res_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    seq_d   = seq_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    wait_d  = wait_q;
    op_d    = op_q;
    reg_d   = reg_q;
    data_d  = data_q;
    stage_d = stage_q;
    half_d  = half_q;
    err_d   = err_q;
    dv_c    = 1'b0;
    db_c    = '0;
    lb_c    = 1'b0;
    done_c  = 1'b0;
    stat_c  = 1'b0;
    left_dec = '0;

    pt        = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
    phase_inc = {1'b0, phase_q} + 9'd1;

    // line levels reflect the state before this item
    unique case (seq_q)
      ST_START: begin
        scl_c = (half_q == 2'd1) || (half_q == 2'd2);
        low_c = half_q[1];
      end
      ST_SEND: begin
        scl_c = half_q[0];
        low_c = !shift_q[7];
      end
      ST_ACK, ST_RECV: begin
        scl_c = half_q[0];
        low_c = 1'b0;
      end
      ST_MACK: begin
        scl_c = half_q[0];
        low_c = (left_q > LeftW'(1));
      end
      ST_STOP: begin
        scl_c = (half_q != 2'd0);
        low_c = (half_q <= 2'd1);
      end
      default: begin
        scl_c = 1'b1;
        low_c = 1'b0;
      end
    endcase

    if (in_i.kind == KIND_CMD) begin
      if (seq_q == ST_IDLE) begin
        op_d   = in_i.op;
        reg_d  = in_i.reg_addr;
        data_d = in_i.wr_data;
        case (in_i.op)
          OP_READ1: left_d = LeftW'(1);
          OP_BURST: left_d = (in_i.burst_len > LeftW'(MaxBurst)) ? LeftW'(MaxBurst)
                                                                 : in_i.burst_len;
          default:  left_d = '0;
        endcase
        stage_d = STG_DEV;
        err_d   = 1'b0;
        wait_d  = '0;
        phase_d = '0;
        bit_d   = '0;
        seq_d   = ST_START;
        half_d  = 2'd1;   // from idle the first start half is skipped
      end
    end else if (seq_q != ST_IDLE) begin
      phase_d = phase_inc[7:0];
      if (phase_inc >= {1'b0, pt}) begin
        phase_d = '0;
        unique case (seq_q)
          ST_START: begin
            if (half_q == 2'd3) begin
              seq_d  = ST_SEND;
              bit_d  = '0;
              half_d = 2'd0;
              if (stage_q == STG_RSTRT) begin
                stage_d = STG_RDEV;
                shift_d = dev_addr_q | ReadBit;
              end else begin
                shift_d = dev_addr_q;
              end
            end else begin
              half_d = half_q + 2'd1;
            end
          end
          ST_SEND: begin
            if (half_q == 2'd0) begin
              half_d = 2'd1;
            end else begin
              half_d  = 2'd0;
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                if (op_q == OP_WAKE) begin
                  seq_d = ST_STOP;
                end else begin
                  seq_d  = ST_ACK;
                  wait_d = '0;
                end
              end
            end
          end
          ST_ACK: begin
            if (half_q == 2'd0) begin
              half_d = 2'd1;
            end else if (!in_i.sda_in) begin
              half_d = 2'd0;
              case (stage_q)
                STG_DEV: begin
                  stage_d = STG_REG;
                  seq_d   = ST_SEND;
                  shift_d = reg_q;
                  bit_d   = '0;
                end
                STG_REG: begin
                  if (op_q == OP_WRITE) begin
                    stage_d = STG_DATA;
                    seq_d   = ST_SEND;
                    shift_d = data_q;
                    bit_d   = '0;
                  end else begin
                    stage_d = STG_RSTRT;
                    seq_d   = ST_START;
                  end
                end
                STG_RDEV: begin
                  if (left_q == '0) begin
                    seq_d = ST_STOP;
                  end else begin
                    seq_d   = ST_RECV;
                    bit_d   = '0;
                    shift_d = '0;
                  end
                end
                default: seq_d = ST_STOP;
              endcase
            end else if (wait_q >= ack_limit_q) begin
              err_d  = 1'b1;
              seq_d  = ST_STOP;
              half_d = 2'd0;
            end else begin
              // keep polling SDA on every further tick
              wait_d  = wait_q + 8'd1;
              phase_d = pt - 8'd1;
            end
          end
          ST_RECV: begin
            if (half_q == 2'd0) begin
              half_d = 2'd1;
            end else begin
              half_d  = 2'd0;
              shift_d = {shift_q[6:0], in_i.sda_in};
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                dv_c  = 1'b1;
                db_c  = shift_d;
                lb_c  = (left_q == LeftW'(1));
                seq_d = ST_MACK;
              end
            end
          end
          ST_MACK: begin
            if (half_q == 2'd0) begin
              half_d = 2'd1;
            end else begin
              half_d   = 2'd0;
              left_dec = (left_q != '0) ? left_q - LeftW'(1) : left_q;
              left_d   = left_dec;
              if (left_dec == '0) begin
                seq_d = ST_STOP;
              end else begin
                seq_d   = ST_RECV;
                shift_d = '0;
              end
            end
          end
          ST_STOP: begin
            if (half_q == 2'd2) begin
              done_c = 1'b1;
              stat_c = err_q;
              seq_d  = ST_IDLE;
              half_d = 2'd0;
            end else begin
              half_d = half_q + 2'd1;
            end
          end
          default: seq_d = ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= '0;
      phase_ticks_q <= PhaseRst;
      ack_limit_q   <= AckLimitRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.addr)
        CFG_DEV_ADDR:  dev_addr_q    <= cfg_i.data;
        CFG_PHASE:     phase_ticks_q <= cfg_i.data;
        CFG_ACK_LIMIT: ack_limit_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= ST_IDLE;
      phase_q <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      wait_q  <= '0;
      op_q    <= '0;
      reg_q   <= '0;
      data_q  <= '0;
      stage_q <= STG_DEV;
      half_q  <= '0;
      err_q   <= 1'b0;
    end else if (in_acc) begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      wait_q  <= wait_d;
      op_q    <= op_d;
      reg_q   <= reg_d;
      data_q  <= data_d;
      stage_q <= stage_d;
      half_q  <= half_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (in_acc) begin
      rvalid_q <= 1'b1;
    end else if (res_o.ready) begin
      rvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scl_q  <= scl_c;
      low_q  <= low_c;
      busy_q <= (seq_d != ST_IDLE);
      dv_q   <= dv_c;
      db_q   <= db_c;
      lb_q   <= lb_c;
      done_q <= done_c;
      stat_q <= stat_c;
    end
  end

  assign res_o.valid         = rvalid_q;
  assign res_o.scl           = scl_q;
  assign res_o.sda_drive_low = low_q;
  assign res_o.busy_res      = busy_q;
  assign res_o.data_valid    = dv_q;
  assign res_o.data_byte     = db_q;
  assign res_o.last_byte     = lb_q;
  assign res_o.done_res      = done_q;
  assign res_o.status        = stat_q;

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q && done_q |-> !busy_q)
    else $error("transaction reported done while still busy");

  a_status_only_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q && !done_q |-> !stat_q)
    else $error("error status without completion");

  a_byte_only_when_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q && !dv_q |-> (db_q == 8'd0) && !lb_q)
    else $error("received byte fields set without data_valid");

  a_byte_enters_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && dv_c |=> seq_q == ST_MACK)
    else $error("received byte not followed by master acknowledge");

endmodule
